// File: rtl/sse_pkg.sv
`timescale 1ns / 1ps

package sse_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Stream payload layout
  localparam int ACTION_W    = 3;
  localparam int IN_VALUE_W  = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_COUNT_W = 7;
  localparam int STATUS_W    = 2;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_COUNT_W - STATUS_W - 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_QUERY  = 3'd1,
    ACT_CLEAR  = 3'd2,
    ACT_MARK   = 3'd3,
    ACT_COMMIT = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Operation broadcast to every cell of the row
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_INSERT,
    OP_MARK,
    OP_CLEAR,
    OP_KILL,
    OP_SWAP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     parity;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_KILL,
    S_SWAP,
    S_RESULT
  } ctrl_state_t;

endpackage

// File: rtl/sse_cell.sv
`timescale 1ns / 1ps

module sse_cell #(
  parameter int INDEX      = 0,
  parameter int CAPACITY   = sse_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = sse_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sse_pkg::cell_cmd_t            cmd,
  input  logic signed [VALUE_BITS-1:0]  key,
  input  logic                          left_gt,
  input  logic                          left_valid,
  input  logic                          left_mark,
  input  logic signed [VALUE_BITS-1:0]  left_value,
  input  logic                          right_valid,
  input  logic signed [VALUE_BITS-1:0]  right_value,
  output logic                          valid,
  output logic                          mark,
  output logic signed [VALUE_BITS-1:0]  value,
  output logic                          gt,
  output logic                          eq
);
  import sse_pkg::*;

  localparam logic LSB       = 1'(INDEX % 2);
  localparam bit   HAS_RIGHT = (INDEX < CAPACITY - 1);
  localparam bit   HAS_LEFT  = (INDEX > 0);

  logic                         valid_next;
  logic                         mark_next;
  logic signed [VALUE_BITS-1:0] value_next;
  logic                         gt_next;
  logic                         eq_next;

  always_comb begin
    valid_next = valid;
    mark_next  = mark;
    value_next = value;
    gt_next    = gt;
    eq_next    = eq;
    unique case (cmd.op)
      OP_CMP: begin
        gt_next = valid && (value > key);
        eq_next = valid && (value == key);
      end
      OP_INSERT: begin
        // shift right behind the insertion point, take the key at it
        if (left_gt) begin
          value_next = left_value;
          mark_next  = left_mark;
          valid_next = 1'b1;
        end else if (left_valid && (gt || !valid)) begin
          value_next = key;
          mark_next  = 1'b0;
          valid_next = 1'b1;
        end
      end
      OP_MARK: begin
        if (eq) mark_next = 1'b1;
      end
      OP_CLEAR: begin
        valid_next = 1'b0;
        mark_next  = 1'b0;
      end
      OP_KILL: begin
        valid_next = valid && mark;
        mark_next  = 1'b0;
      end
      OP_SWAP: begin
        // odd-even pass: a live entry moves left past an empty slot
        if (HAS_RIGHT && cmd.parity == LSB) begin
          if (!valid && right_valid) begin
            value_next = right_value;
            valid_next = 1'b1;
          end
        end else if (HAS_LEFT && cmd.parity != LSB) begin
          if (!left_valid && valid) begin
            value_next = left_value;
            valid_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      mark  <= 1'b0;
      gt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      valid <= valid_next;
      mark  <= mark_next;
      gt    <= gt_next;
      eq    <= eq_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// File: rtl/sse_ctrl.sv
`timescale 1ns / 1ps

module sse_ctrl #(
  parameter int CAPACITY   = sse_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = sse_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sse_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [sse_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic [CAPACITY-1:0]              eq_vec,
  input  logic [CAPACITY-1:0]              mark_vec,
  output sse_pkg::cell_cmd_t               cmd,
  output logic signed [VALUE_BITS-1:0]     key
);
  import sse_pkg::*;

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int SCW = $clog2(CAPACITY);

  ctrl_state_t          state, state_next;
  action_t              action;
  logic [CW-1:0]        count;
  logic [CW-1:0]        mark_count;
  logic [SCW-1:0]       swap_cnt;
  logic                 res_found;
  status_t              res_status;

  logic                        present;
  logic                        already_marked;
  logic signed [IN_VALUE_W-1:0] in_value;
  logic signed [63:0]          in_wide;
  logic                        load_out;

  assign present        = |eq_vec;
  assign already_marked = |(eq_vec & mark_vec);
  assign in_value       = signed'(s_tdata[ACTION_W +: IN_VALUE_W]);
  assign in_wide        = 64'(in_value);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd.op     = OP_HOLD;
    cmd.parity = swap_cnt[0];
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = S_CMP;
      end
      S_CMP: begin
        cmd.op     = OP_CMP;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        state_next = S_RESULT;
        unique case (action)
          ACT_INSERT: if (!present && count != CW'(CAPACITY)) cmd.op = OP_INSERT;
          ACT_CLEAR:  cmd.op = OP_CLEAR;
          ACT_MARK:   cmd.op = OP_MARK;
          ACT_COMMIT: state_next = S_KILL;
          default: begin
          end
        endcase
      end
      S_KILL: begin
        cmd.op     = OP_KILL;
        state_next = S_SWAP;
      end
      S_SWAP: begin
        cmd.op = OP_SWAP;
        if (swap_cnt == SCW'(CAPACITY - 1)) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Item capture and result bookkeeping
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      action <= action_t'(s_tdata[ACTION_W-1:0]);
      key    <= in_wide[VALUE_BITS-1:0];
    end
    if (state == S_APPLY) begin
      unique case (action)
        ACT_INSERT: begin
          res_found <= present;
          if (present)                     res_status <= ST_DUP;
          else if (count == CW'(CAPACITY)) res_status <= ST_FULL;
          else                             res_status <= ST_DONE;
        end
        ACT_QUERY, ACT_MARK: begin
          res_found  <= present;
          res_status <= ST_DONE;
        end
        default: begin
          res_found  <= 1'b0;
          res_status <= ST_DONE;
        end
      endcase
    end
    if (state == S_KILL) swap_cnt <= '0;
    else if (state == S_SWAP) swap_cnt <= swap_cnt + 1'b1;
    if (load_out) m_tdata <= {OUT_PAD_W'(0), OUT_COUNT_W'(count), res_status, res_found};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      mark_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.op == OP_INSERT) count <= count + 1'b1;
      if (cmd.op == OP_CLEAR) begin
        count      <= '0;
        mark_count <= '0;
      end
      if (cmd.op == OP_MARK && present && !already_marked) mark_count <= mark_count + 1'b1;
      if (cmd.op == OP_KILL) begin
        count      <= mark_count;
        mark_count <= '0;
      end
      if (load_out)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

// File: rtl/sorted_set_engine_top.sv
`timescale 1ns / 1ps

// Sorted set engine: holds up to CAPACITY distinct signed values in ascending
// order in a row of cells, one entry per cell.
// Input channel (s_*): one transfer per operation; tdata carries the action
// (insert, query, clear, intersect mark, intersect commit) and the value.
// Output channel (m_*): exactly one result transfer per input transfer, in
// order: found flag, status (done, duplicate, full) and the entry count.
// Every action except commit is worked in steps after the input transfer:
// all cells compare against the key, then they apply the action
// (shift-insert, mark or clear), then the result is loaded into the output
// register. A new item is taken only once the last result is loaded.
// Commit first drops the unmarked entries, then CAPACITY odd-even swap
// passes across the cell row slide the survivors down in order, and the
// result is loaded last.
// Reset (rst, synchronous, active high) empties the set and drops all marks.
// A stalled receiver holds the result in the output register; the next
// item is still taken and worked, and its result waits until the register
// frees up.
module sorted_set_engine_top #(
  parameter int CAPACITY   = sse_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = sse_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [2:0] action, [34:3] value, [39:35] zero
  input  logic [sse_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] found, [2:1] status, [9:3] count, [15:10] zero
  output logic [sse_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import sse_pkg::*;

  cell_cmd_t                    cmd;
  logic signed [VALUE_BITS-1:0] key;
  logic [CAPACITY-1:0]          valid_vec;
  logic [CAPACITY-1:0]          mark_vec;
  logic [CAPACITY-1:0]          gt_vec;
  logic [CAPACITY-1:0]          eq_vec;
  logic signed [VALUE_BITS-1:0] value_arr [CAPACITY];

  sse_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .eq_vec   (eq_vec),
    .mark_vec (mark_vec),
    .cmd      (cmd),
    .key      (key)
  );

  // Cell row: each cell sees its left and right neighbor only
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                         l_gt, l_valid, l_mark, r_valid;
    logic signed [VALUE_BITS-1:0] l_value, r_value;

    if (i == 0) begin : g_head
      // head acts as if a smaller live entry sat to its left
      assign l_gt    = 1'b0;
      assign l_valid = 1'b1;
      assign l_mark  = 1'b0;
      assign l_value = key;
    end else begin : g_body
      assign l_gt    = gt_vec[i-1];
      assign l_valid = valid_vec[i-1];
      assign l_mark  = mark_vec[i-1];
      assign l_value = value_arr[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_value = key;
    end else begin : g_inner
      assign r_valid = valid_vec[i+1];
      assign r_value = value_arr[i+1];
    end

    sse_cell #(
      .INDEX      (i),
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .key         (key),
      .left_gt     (l_gt),
      .left_valid  (l_valid),
      .left_mark   (l_mark),
      .left_value  (l_value),
      .right_valid (r_valid),
      .right_value (r_value),
      .valid       (valid_vec[i]),
      .mark        (mark_vec[i]),
      .value       (value_arr[i]),
      .gt          (gt_vec[i]),
      .eq          (eq_vec[i])
    );
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the sorted set engine. The driver pops operations
// from a queue that the stimulus block fills at time zero, predicts the
// result of each transfer as it is accepted, and the monitor compares every
// output transfer, field by field, against the oldest prediction.
module tb_top;
  import sse_pkg::*;

  localparam int SET_CAPACITY  = CAPACITY_DEF;
  localparam int POOL_SIZE     = 80;
  localparam int TARGET_OPS    = 1750;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = SET_CAPACITY + 12;
  localparam int HOLDOFF_LEN   = 400;
  localparam int MAX_REPORTS   = 10;

  // Action codes the engine treats as no-ops
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  localparam logic [IN_VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [IN_VALUE_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [IN_VALUE_W-1:0] VAL_ONES = 32'hFFFF_FFFF;

  typedef struct {
    logic [ACTION_W-1:0]   act;
    logic [IN_VALUE_W-1:0] val;
  } set_op_t;

  typedef struct packed {
    logic                   found;
    status_t                status;
    logic [OUT_COUNT_W-1:0] count;
  } set_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  sorted_set_engine_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the engine contents: ascending values with their marks
  int signed   held_vals[$];
  bit          held_marks[$];

  set_op_t     op_queue[$];
  set_result_t awaited_results[$];
  int          ops_total;
  int          ops_sent;
  int          results_seen;
  int          mismatches;
  int          cycle_count;

  // Coverage tallies for the closing summary
  int          n_added, n_dup, n_full, n_hits, n_marked, n_commits, n_clears, peak_count;

  logic [IN_VALUE_W-1:0] value_pool[POOL_SIZE];

  // Apply one operation to the shadow set and return the result it must cause
  function automatic set_result_t apply_set_op(logic [ACTION_W-1:0] act,
                                               logic [IN_VALUE_W-1:0] raw);
    int signed   key;
    int          pos;
    bit          present;
    set_result_t res;
    int signed   kept_vals[$];
    key = signed'(raw);
    res = '{found: 1'b0, status: ST_DONE, count: '0};
    pos = 0;
    while (pos < held_vals.size() && held_vals[pos] < key) pos++;
    present = (pos < held_vals.size()) && (held_vals[pos] == key);
    case (act)
      ACT_INSERT: begin
        res.found = present;
        if (present) begin
          res.status = ST_DUP;
          n_dup++;
        end else if (held_vals.size() >= SET_CAPACITY) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          held_vals.insert(pos, key);
          held_marks.insert(pos, 1'b0);
          n_added++;
        end
      end
      ACT_QUERY: begin
        res.found = present;
      end
      ACT_CLEAR: begin
        held_vals.delete();
        held_marks.delete();
        n_clears++;
      end
      ACT_MARK: begin
        res.found = present;
        if (present) begin
          held_marks[pos] = 1'b1;
          n_marked++;
        end
      end
      ACT_COMMIT: begin
        // Keep marked entries in order, drop every mark
        foreach (held_vals[i]) if (held_marks[i]) kept_vals.insert(kept_vals.size(), held_vals[i]);
        held_vals = kept_vals;
        held_marks.delete();
        foreach (held_vals[i]) held_marks.insert(i, 1'b0);
        n_commits++;
      end
      default: ;
    endcase
    if (present && (act == ACT_INSERT || act == ACT_QUERY || act == ACT_MARK)) n_hits++;
    if (held_vals.size() > peak_count) peak_count = held_vals.size();
    res.count = OUT_COUNT_W'(held_vals.size());
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_op(logic [ACTION_W-1:0] act, logic [IN_VALUE_W-1:0] val);
    set_op_t item;
    item.act = act;
    item.val = val;
    op_queue.insert(op_queue.size(), item);
    if (act <= ACT_COMMIT) ops_total++;
  endtask

  task automatic refill_pool();
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    for (int i = 2; i < POOL_SIZE; i++) begin
      // Clustered small values interleave with scattered full-range ones
      if ($urandom_range(0, 99) < 30) value_pool[i] = $urandom_range(0, 200) - 100;
      else value_pool[i] = $urandom();
    end
  endtask

  function automatic logic [IN_VALUE_W-1:0] pick_value(int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // Directed corner cases, then random episodes of well-formed sequences
  task automatic build_stimulus();
    int n;
    int kind;
    push_op(ACT_INSERT, VAL_MIN);
    push_op(ACT_INSERT, VAL_MAX);
    push_op(ACT_INSERT, 32'h0);
    push_op(ACT_INSERT, VAL_ONES);
    push_op(ACT_INSERT, 32'h0);            // duplicate
    push_op(ACT_QUERY, VAL_MAX);
    push_op(ACT_QUERY, 32'h1);             // absent
    push_op(ACT_MARK, VAL_MIN);
    push_op(ACT_MARK, 32'h5);              // absent value, nothing changes
    push_op(ACT_INSERT, 32'h7);            // arrives unmarked while marks pend
    push_op(ACT_MARK, VAL_ONES);
    push_op(ACT_COMMIT, 32'h0);            // keeps min and -1
    push_op(ACT_QUERY, VAL_MIN);
    push_op(ACT_QUERY, 32'h7);
    push_op(ACT_SPARE_FIRST, VAL_ONES);
    push_op(ACT_SPARE_FIRST + 3'd1, 32'h5555_5555);
    push_op(ACT_SPARE_LAST, 32'hAAAA_AAAA);
    push_op(ACT_MARK, VAL_ONES);
    push_op(ACT_CLEAR, VAL_ONES);          // also drops the pending mark
    push_op(ACT_QUERY, VAL_ONES);
    push_op(ACT_COMMIT, VAL_MAX);          // empty set
    push_op(ACT_MARK, 32'h0);
    push_op(ACT_INSERT, 32'h5555_5555);
    push_op(ACT_INSERT, 32'hAAAA_AAAA);
    push_op(ACT_COMMIT, 32'h0);            // nothing marked, set empties

    refill_pool();
    while (ops_total < TARGET_OPS) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        n = $urandom_range(1, 40);
        repeat (n) push_op(ACT_INSERT, pick_value(85));
      end else if (kind < 58) begin
        n = $urandom_range(1, 10);
        repeat (n) push_op(ACT_QUERY, pick_value(70));
      end else if (kind < 80) begin
        n = $urandom_range(1, 30);
        repeat (n) begin
          if ($urandom_range(0, 99) < 12) push_op(ACT_INSERT, pick_value(60));
          else push_op(ACT_MARK, pick_value(80));
        end
        // Occasionally leave marks pending into the next episode
        if ($urandom_range(0, 99) < 88) push_op(ACT_COMMIT, $urandom());
      end else if (kind < 90) begin
        push_op(ACT_CLEAR, $urandom());
        refill_pool();
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          if ($urandom_range(0, 1))
            push_op(ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)), $urandom());
          else push_op(ACTION_W'($urandom_range(0, 7)), pick_value(50));
        end
      end
    end
  endtask

  // Driver: offer queued operations, predict each one at its transfer
  set_op_t offered_op;
  int      tx_gap_left;
  int      tx_smooth_left;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      tx_gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_results.insert(awaited_results.size(),
                               apply_set_op(offered_op.act, offered_op.val));
        ops_sent <= ops_sent + 1;
      end
      // Channel is free when nothing is offered or the offer just transferred
      if (!s_tvalid || s_tready) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          s_tvalid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          offered_op = op_queue.pop_front();
          s_tdata  <= {{(IN_TDATA_W - IN_VALUE_W - ACTION_W){1'b0}},
                       offered_op.val, offered_op.act};
          s_tvalid <= 1'b1;
          if (tx_smooth_left > 0) begin
            tx_smooth_left--;
          end else if ($urandom_range(0, 99) < 3) begin
            tx_smooth_left = $urandom_range(40, 150);
          end else begin
            tx_gap_left = pick_idle_len();
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, runs without stalls, and two long hold-offs
  // that let the engine back up and stall its input
  int rx_stall_left;
  int rx_smooth_left;
  int holdoff_left;
  int holdoffs_done;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      m_tready <= 1'b0;
    end else if (holdoffs_done < 2 && ops_sent >= 400 + 700 * holdoffs_done) begin
      holdoff_left = HOLDOFF_LEN;
      holdoffs_done++;
      m_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (rx_smooth_left > 0) begin
        rx_smooth_left--;
      end else if ($urandom_range(0, 99) < 3) begin
        rx_smooth_left = $urandom_range(40, 150);
      end else if ($urandom_range(0, 99) < 40) begin
        rx_stall_left = pick_idle_len();
      end
    end
  end

  // Monitor: every output transfer must match the oldest prediction
  set_result_t got_res;
  set_result_t want_res;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res.found  = m_tdata[0];
      got_res.status = status_t'(m_tdata[STATUS_W:1]);
      got_res.count  = m_tdata[OUT_COUNT_W + STATUS_W:STATUS_W + 1];
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: found=%0d status=%0d count=%0d",
                   $realtime, got_res.found, got_res.status, got_res.count);
      end else begin
        want_res = awaited_results.pop_front();
        if (got_res.found !== want_res.found || got_res.status !== want_res.status ||
            got_res.count !== want_res.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] result %0d: expected found=%0d status=%0d count=%0d",
                     $realtime, results_seen, want_res.found, want_res.status,
                     want_res.count);
            $display("  got found=%0d status=%0d count=%0d",
                     got_res.found, got_res.status, got_res.count);
          end
        end
      end
      results_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d operations sent, %0d results pending",
               cycle_count, ops_sent, op_queue.size() + ops_sent, awaited_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int n_queued;
    build_stimulus();
    n_queued = op_queue.size();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (ops_sent < n_queued) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    // Hold for the slowest action's latency so stray results still show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d operations (%0d results): %0d added, %0d duplicates, %0d full drops,",
             ops_sent, results_seen, n_added, n_dup, n_full);
    $display("  %0d hits, %0d marks, %0d commits, %0d clears, peak size %0d, %0d mismatches",
             n_hits, n_marked, n_commits, n_clears, peak_count, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sse_pkg.sv
rtl/sse_cell.sv
rtl/sse_ctrl.sv
rtl/sorted_set_engine_top.sv
tb/sv/tb_top.sv
